// ===== rtl/lmcr_pkg.sv =====
// Shared types, register codes and frame helpers for the LED-matrix chain refresh block.
// Used by every module of the block; depends on nothing.
package lmcr_pkg;

    localparam int unsigned CHAIN_LENGTH_DEFAULT = 4;
    localparam int unsigned MAX_CHAIN            = 4;
    localparam int unsigned QUEUE_DEPTH          = 4;
    localparam int unsigned BUF_DEPTH            = 32;

    localparam logic [2:0] ROW_LAST       = 3'd7;
    localparam logic [2:0] INIT_LAST_STEP = 3'd5;

    // Driver register addresses.
    localparam logic [7:0] REG_IDLE       = 8'h00;
    localparam logic [7:0] REG_DIGIT_BASE = 8'h01;
    localparam logic [7:0] REG_DECODE     = 8'h09;
    localparam logic [7:0] REG_BRIGHT     = 8'h0A;
    localparam logic [7:0] REG_ROW_SPAN   = 8'h0B;
    localparam logic [7:0] REG_POWER      = 8'h0C;
    localparam logic [7:0] REG_TEST       = 8'h0F;

    // Register data used by the setup sequence and the brightness clamp.
    localparam logic [7:0] DATA_OFF       = 8'h00;
    localparam logic [7:0] DATA_ON        = 8'h01;
    localparam logic [7:0] SCAN_ALL_ROWS  = 8'h07;
    localparam logic [7:0] INIT_INTENSITY = 8'h08;
    localparam logic [7:0] MAX_INTENSITY  = 8'd15;

    typedef enum logic [2:0] {
        OP_SET_PIXEL  = 3'd0,
        OP_SET_ROW    = 3'd1,
        OP_BRIGHTNESS = 3'd2,
        OP_REFRESH    = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_INIT       = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_RUN
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [4:0] idx;
        logic [2:0] col;
        logic       pixel_on;
        logic [7:0] value;
    } t_cmd;

    // Same word in every populated chain position.
    function automatic logic [63:0] broadcast(input logic [15:0] word, input int unsigned n);
        logic [63:0] f;
        f = '0;
        for (int i = 0; i < MAX_CHAIN; i++) begin
            if (i < n) begin
                f[63 - 16*i -: 16] = word;
            end
        end
        return f;
    endfunction

    function automatic logic [15:0] init_word(input logic [2:0] step);
        logic [15:0] w;
        case (step)
            3'd0:    w = {REG_POWER, DATA_OFF};
            3'd1:    w = {REG_DECODE, DATA_OFF};
            3'd2:    w = {REG_ROW_SPAN, SCAN_ALL_ROWS};
            3'd3:    w = {REG_BRIGHT, INIT_INTENSITY};
            3'd4:    w = {REG_TEST, DATA_OFF};
            3'd5:    w = {REG_POWER, DATA_ON};
            default: w = {REG_IDLE, DATA_OFF};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/led_matrix_chain_refresh.sv =====
// A brightness frame passes the command queue and the output register; a refresh frame passes
// the queue, the sequencer state and the output register. Buffer writes retire one per cycle while
// the sequencer is idle; refresh, clear and init frames come from the one-frame-per-cycle sequencer,
// which any output stall holds. A 4-entry command queue lets input continue during a refresh.
// Reset is synchronous, active low: it empties the queue, clears the pixel buffer at once
// and drops any pending output frame.
module led_matrix_chain_refresh #(
    parameter int unsigned CHAIN_LENGTH = lmcr_pkg::CHAIN_LENGTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [1:0]  i_device,
    input  logic [2:0]  i_row,
    input  logic [2:0]  i_col,
    input  logic        i_pixel_on,
    input  logic [7:0]  i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_frame,
    output logic        o_last_frame
);

    logic           push;
    logic           full;
    logic           pop;
    logic           empty;
    lmcr_pkg::t_cmd front_cmd;
    lmcr_pkg::t_cmd head_cmd;

    assign o_in_stall = full;

    lmcr_front #(.CHAIN_LENGTH(CHAIN_LENGTH)) u_front (
        .i_valid     (i_in_valid),
        .i_full      (full),
        .i_operation (i_operation),
        .i_device    (i_device),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_pixel_on  (i_pixel_on),
        .i_value     (i_value),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    lmcr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (empty)
    );

    lmcr_back #(.CHAIN_LENGTH(CHAIN_LENGTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_frame      (o_frame),
        .o_last_frame (o_last_frame)
    );

endmodule

// ===== rtl/lmcr_front.sv =====
// Front end: takes input transactions, drops ignored ones and turns the rest into commands.
// Depends on lmcr_pkg for the command type and operation codes.
module lmcr_front #(
    parameter int unsigned CHAIN_LENGTH = lmcr_pkg::CHAIN_LENGTH_DEFAULT
) (
    input  logic            i_valid,
    input  logic            i_full,
    input  logic [2:0]      i_operation,
    input  logic [1:0]      i_device,
    input  logic [2:0]      i_row,
    input  logic [2:0]      i_col,
    input  logic            i_pixel_on,
    input  logic [7:0]      i_value,
    output logic            o_push,
    output lmcr_pkg::t_cmd  o_cmd
);

    logic accept;
    logic in_chain;
    logic keep;

    assign accept   = i_valid && !i_full;
    assign in_chain = ({1'b0, i_device} < 3'(CHAIN_LENGTH));

    always_comb begin
        o_cmd.op       = lmcr_pkg::t_op'(i_operation);
        o_cmd.idx      = {i_device, i_row};
        o_cmd.col      = i_col;
        o_cmd.pixel_on = i_pixel_on;
        o_cmd.value    = i_value;
        keep           = 1'b0;
        case (lmcr_pkg::t_op'(i_operation))
            lmcr_pkg::OP_SET_PIXEL,
            lmcr_pkg::OP_SET_ROW: begin
                keep = in_chain;
            end
            lmcr_pkg::OP_BRIGHTNESS: begin
                keep = 1'b1;
                if (i_value > lmcr_pkg::MAX_INTENSITY) begin
                    o_cmd.value = lmcr_pkg::MAX_INTENSITY;
                end
            end
            lmcr_pkg::OP_REFRESH,
            lmcr_pkg::OP_CLEAR,
            lmcr_pkg::OP_INIT: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = accept && keep;

endmodule

// ===== rtl/lmcr_fifo.sv =====
// Short command queue between the front end and the frame sequencer.
// Depends on lmcr_pkg for the command type and queue depth.
module lmcr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lmcr_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output lmcr_pkg::t_cmd  o_data,
    output logic            o_empty
);

    localparam int unsigned PW = $clog2(lmcr_pkg::QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(lmcr_pkg::QUEUE_DEPTH + 1);

    lmcr_pkg::t_cmd r_mem [lmcr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(lmcr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/lmcr_back.sv =====
// Back end: holds the pixel buffer and sequences the chain frames into an output register.
// Depends on lmcr_pkg for the command type, state type, register codes and frame helpers.
module lmcr_back #(
    parameter int unsigned CHAIN_LENGTH = lmcr_pkg::CHAIN_LENGTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  lmcr_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [63:0]     o_frame,
    output logic            o_last_frame
);

    localparam logic [1:0] DEV_LAST = 2'(CHAIN_LENGTH - 1);

    lmcr_pkg::t_state r_state, n_state;
    logic [2:0]       r_step, n_step;
    logic [2:0]       r_row, n_row;
    logic [1:0]       r_dev, n_dev;
    logic             r_out_valid, n_out_valid;
    logic [63:0]      r_frame, n_frame;
    logic             r_last, n_last;
    logic [7:0]       r_pix [lmcr_pkg::BUF_DEPTH];

    logic       out_ready;
    logic [4:0] rd_idx;
    logic [7:0] rd_byte;
    logic [7:0] bit_mask;
    logic       pix_wr;
    logic       pix_clr;
    logic [7:0] pix_wdata;
    logic [15:0] digit_word;

    assign out_ready = !r_out_valid || !i_stall;
    // One read port: the refresh scan owns it while running, the queue head otherwise.
    assign rd_idx    = (r_state == lmcr_pkg::ST_RUN) ? {r_dev, r_row} : i_cmd.idx;
    assign rd_byte   = r_pix[rd_idx];
    assign bit_mask  = 8'd1 << i_cmd.col;
    assign digit_word = {lmcr_pkg::REG_DIGIT_BASE + {5'b0, r_row}, rd_byte};

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_row       = r_row;
        n_dev       = r_dev;
        n_out_valid = r_out_valid && i_stall;
        n_frame     = r_frame;
        n_last      = r_last;
        o_pop       = 1'b0;
        pix_wr      = 1'b0;
        pix_clr     = 1'b0;
        pix_wdata   = i_cmd.value;
        case (r_state)
            lmcr_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.op)
                        lmcr_pkg::OP_SET_PIXEL: begin
                            o_pop     = 1'b1;
                            pix_wr    = 1'b1;
                            pix_wdata = i_cmd.pixel_on ? (rd_byte | bit_mask)
                                                       : (rd_byte & ~bit_mask);
                        end
                        lmcr_pkg::OP_SET_ROW: begin
                            o_pop  = 1'b1;
                            pix_wr = 1'b1;
                        end
                        lmcr_pkg::OP_BRIGHTNESS: begin
                            if (out_ready) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_frame     = lmcr_pkg::broadcast(
                                    {lmcr_pkg::REG_BRIGHT, i_cmd.value}, CHAIN_LENGTH);
                                n_last      = 1'b1;
                            end
                        end
                        lmcr_pkg::OP_REFRESH: begin
                            o_pop   = 1'b1;
                            n_state = lmcr_pkg::ST_RUN;
                            n_row   = '0;
                            n_dev   = '0;
                        end
                        lmcr_pkg::OP_CLEAR: begin
                            o_pop   = 1'b1;
                            pix_clr = 1'b1;
                            n_state = lmcr_pkg::ST_RUN;
                            n_row   = '0;
                            n_dev   = '0;
                        end
                        lmcr_pkg::OP_INIT: begin
                            o_pop   = 1'b1;
                            n_state = lmcr_pkg::ST_INIT;
                            n_step  = '0;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            lmcr_pkg::ST_INIT: begin
                if (out_ready) begin
                    n_out_valid = 1'b1;
                    n_frame     = lmcr_pkg::broadcast(lmcr_pkg::init_word(r_step),
                                                      CHAIN_LENGTH);
                    n_last      = 1'b0;
                    n_step      = r_step + 3'd1;
                    if (r_step == lmcr_pkg::INIT_LAST_STEP) begin
                        // The last setup step clears the whole buffer and starts the refresh scan.
                        pix_clr = 1'b1;
                        n_state = lmcr_pkg::ST_RUN;
                        n_row   = '0;
                        n_dev   = '0;
                    end
                end
            end
            lmcr_pkg::ST_RUN: begin
                if (out_ready) begin
                    n_out_valid = 1'b1;
                    n_frame     = {digit_word, 48'b0} >> {r_dev, 4'b0};
                    n_last      = (r_row == lmcr_pkg::ROW_LAST) && (r_dev == DEV_LAST);
                    if (r_dev == DEV_LAST) begin
                        n_dev = '0;
                        n_row = r_row + 3'd1;
                        if (r_row == lmcr_pkg::ROW_LAST) begin
                            n_state = lmcr_pkg::ST_IDLE;
                        end
                    end else begin
                        n_dev = r_dev + 2'd1;
                    end
                end
            end
            default: begin
                n_state = lmcr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmcr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_row       <= '0;
            r_dev       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_row       <= n_row;
            r_dev       <= n_dev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        r_last  <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || pix_clr) begin
            for (int i = 0; i < lmcr_pkg::BUF_DEPTH; i++) begin
                r_pix[i] <= '0;
            end
        end else if (pix_wr) begin
            r_pix[i_cmd.idx] <= pix_wdata;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame      = r_frame;
    assign o_last_frame = r_last;

endmodule

// ===== rtl/lmcr_checker.sv =====
// Port-level checks for the LED-matrix chain refresh block, bound to its top level.
// Depends only on the top level's ports and its CHAIN_LENGTH parameter.
module lmcr_checker #(
    parameter int unsigned CHAIN_LENGTH = 4
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_frame,
    input logic        o_last_frame
);

    localparam logic [63:0] UNUSED_MASK =
        (CHAIN_LENGTH >= 4) ? 64'd0 : ({64{1'b1}} >> (16 * CHAIN_LENGTH));

    // A stalled output transaction holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame)
                                       && $stable(o_last_frame))
        else $error("output frame changed while stalled");

    // Reset drops any pending frame.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Chain positions past the last device never carry a word.
    a_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_frame & UNUSED_MASK) == 64'd0))
        else $error("word in an unpopulated chain position");

    // Frames of one operation go out back to back until the last one.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_frame |=> o_out_valid)
        else $error("gap inside a frame sequence");

endmodule

bind led_matrix_chain_refresh lmcr_checker #(.CHAIN_LENGTH(CHAIN_LENGTH)) u_lmcr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_frame      (o_frame),
    .o_last_frame (o_last_frame)
);

// ===== sim/tb.sv =====
// Self-checking testbench for led_matrix_chain_refresh: a directed table, then random commands.
// Depends on rtl/lmcr_pkg.sv and rtl/led_matrix_chain_refresh.sv.
module tb;

    localparam int unsigned CHAIN    = 4;
    localparam int unsigned ROWS     = 8;
    localparam int          N_RANDOM = 77;
    localparam int          LIMIT    = 500000;

    // Codes the block decodes to nothing.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_FRAME,
        CHK_NONE
    } t_chk_kind;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  dev;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        on;
        logic [7:0]  value;
        t_chk_kind   kind;
        logic [63:0] frame;
    } t_cmd_row;

    typedef struct packed {
        logic [63:0] frame;
        logic        last;
    } t_chain_frame;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        o_in_stall;
    logic [2:0]  in_op;
    logic [1:0]  in_dev;
    logic [2:0]  in_row;
    logic [2:0]  in_col;
    logic        in_on;
    logic [7:0]  in_value;
    logic        o_out_valid;
    logic        out_stall;
    logic [63:0] o_frame;
    logic        o_last_frame;

    // Typed expectation that travels with the current transaction.
    t_chk_kind   cur_kind;
    logic [63:0] cur_frame;

    logic [7:0]   pix_model [lmcr_pkg::BUF_DEPTH];
    t_chain_frame expected_frames [$];
    t_cmd_row     directed_rows [$];
    int           err_count;
    int           cycle_count;
    logic         calm;

    led_matrix_chain_refresh #(
        .CHAIN_LENGTH(CHAIN)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (in_op),
        .i_device     (in_dev),
        .i_row        (in_row),
        .i_col        (in_col),
        .i_pixel_on   (in_on),
        .i_value      (in_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_frame      (o_frame),
        .o_last_frame (o_last_frame)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [63:0] place_word(input int unsigned pos, input logic [15:0] word);
        logic [63:0] f;
        f = '0;
        f[63 - 16*pos -: 16] = word;
        return f;
    endfunction

    function automatic logic [63:0] all_positions(input logic [15:0] word);
        logic [63:0] f;
        f = '0;
        for (int i = 0; i < CHAIN; i++) begin
            f |= place_word(i, word);
        end
        return f;
    endfunction

    task automatic push_frame(input logic [63:0] frame);
        t_chain_frame e;
        e.frame = frame;
        e.last  = 1'b0;
        expected_frames.push_back(e);
    endtask

    task automatic push_refresh();
        logic [15:0] w;
        for (int r = 0; r < ROWS; r++) begin
            for (int d = 0; d < CHAIN; d++) begin
                w = {lmcr_pkg::REG_DIGIT_BASE + 8'(r), pix_model[d*ROWS + r]};
                push_frame(place_word(d, w));
            end
        end
    endtask

    task automatic push_clear();
        for (int i = 0; i < lmcr_pkg::BUF_DEPTH; i++) begin
            pix_model[i] = 8'h00;
        end
        push_refresh();
    endtask

    // Updates the pixel model and queues the frames one command produces.
    task automatic predict_frames(input logic [2:0] op, input logic [1:0] dev,
                                  input logic [2:0] row, input logic [2:0] col,
                                  input logic on, input logic [7:0] value);
        int          idx;
        int          n_before;
        logic [7:0]  level;
        idx      = int'(dev) * ROWS + int'(row);
        n_before = expected_frames.size();
        case (op)
            lmcr_pkg::OP_SET_PIXEL: begin
                if (dev < CHAIN) begin
                    pix_model[idx][col] = on;
                end
            end
            lmcr_pkg::OP_SET_ROW: begin
                if (dev < CHAIN) begin
                    pix_model[idx] = value;
                end
            end
            lmcr_pkg::OP_BRIGHTNESS: begin
                level = (value > lmcr_pkg::MAX_INTENSITY) ? lmcr_pkg::MAX_INTENSITY : value;
                push_frame(all_positions({lmcr_pkg::REG_BRIGHT, level}));
            end
            lmcr_pkg::OP_REFRESH: push_refresh();
            lmcr_pkg::OP_CLEAR:   push_clear();
            lmcr_pkg::OP_INIT: begin
                push_frame(all_positions({lmcr_pkg::REG_POWER, lmcr_pkg::DATA_OFF}));
                push_frame(all_positions({lmcr_pkg::REG_DECODE, lmcr_pkg::DATA_OFF}));
                push_frame(all_positions({lmcr_pkg::REG_ROW_SPAN, lmcr_pkg::SCAN_ALL_ROWS}));
                push_frame(all_positions({lmcr_pkg::REG_BRIGHT, lmcr_pkg::INIT_INTENSITY}));
                push_frame(all_positions({lmcr_pkg::REG_TEST, lmcr_pkg::DATA_OFF}));
                push_frame(all_positions({lmcr_pkg::REG_POWER, lmcr_pkg::DATA_ON}));
                push_clear();
            end
            default: ;
        endcase
        if (expected_frames.size() > n_before) begin
            expected_frames[expected_frames.size() - 1].last = 1'b1;
        end
    endtask

    task automatic add_row(input logic [2:0] op, input logic [1:0] dev, input logic [2:0] row,
                           input logic [2:0] col, input logic on, input logic [7:0] value,
                           input t_chk_kind kind, input logic [63:0] frame);
        t_cmd_row r;
        r.op    = op;
        r.dev   = dev;
        r.row   = row;
        r.col   = col;
        r.on    = on;
        r.value = value;
        r.kind  = kind;
        r.frame = frame;
        directed_rows.push_back(r);
    endtask

    function automatic t_cmd_row random_cmd();
        t_cmd_row r;
        int       p;
        p       = $urandom_range(0, 99);
        r.dev   = 2'($urandom_range(0, 3));
        r.row   = 3'($urandom_range(0, 7));
        r.col   = 3'($urandom_range(0, 7));
        r.on    = 1'($urandom_range(0, 1));
        r.value = 8'($urandom_range(0, 255));
        r.kind  = CHK_MODEL;
        r.frame = '0;
        if (p < 35) begin
            r.op = lmcr_pkg::OP_SET_PIXEL;
        end else if (p < 65) begin
            r.op = lmcr_pkg::OP_SET_ROW;
        end else if (p < 75) begin
            r.op = lmcr_pkg::OP_BRIGHTNESS;
            // Keep many intensities near the clamp point.
            if ($urandom_range(0, 1) == 0) begin
                r.value = 8'($urandom_range(0, 31));
            end
        end else if (p < 87) begin
            r.op = lmcr_pkg::OP_REFRESH;
        end else if (p < 92) begin
            r.op = lmcr_pkg::OP_CLEAR;
        end else if (p < 96) begin
            r.op = lmcr_pkg::OP_INIT;
        end else begin
            r.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
        end
        return r;
    endfunction

    task automatic send_cmd(input t_cmd_row r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_op     <= r.op;
        in_dev    <= r.dev;
        in_row    <= r.row;
        in_col    <= r.col;
        in_on     <= r.on;
        in_value  <= r.value;
        cur_kind  <= r.kind;
        cur_frame <= r.frame;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Result checking and expectation capture share one edge-triggered block.
    always @(posedge i_clk) begin
        t_chain_frame e;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected frame %h last %b", $time, o_frame, o_last_frame);
                    err_count++;
                end else begin
                    e = expected_frames.pop_front();
                    if (o_frame !== e.frame) begin
                        $display("%0t: frame expected %h actual %h", $time, e.frame, o_frame);
                        err_count++;
                    end
                    if (o_last_frame !== e.last) begin
                        $display("%0t: last_frame expected %b actual %b",
                                 $time, e.last, o_last_frame);
                        err_count++;
                    end
                end
            end
            if (in_valid && !o_in_stall) begin
                case (cur_kind)
                    CHK_FRAME: begin
                        e.frame = cur_frame;
                        e.last  = 1'b1;
                        expected_frames.push_back(e);
                    end
                    CHK_NONE: ;
                    default: predict_frames(in_op, in_dev, in_row, in_col, in_on, in_value);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("FAIL led_matrix_chain_refresh");
            $finish;
        end
    end

    // Frame sink: stalls a random number of cycles before each frame, and not at all while calm.
    initial begin
        int n;
        out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            n = calm ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_op       = '0;
        in_dev      = '0;
        in_row      = '0;
        in_col      = '0;
        in_on       = 1'b0;
        in_value    = '0;
        cur_kind    = CHK_MODEL;
        cur_frame   = '0;
        calm        = 1'b0;
        err_count   = 0;
        cycle_count = 0;
        for (int i = 0; i < lmcr_pkg::BUF_DEPTH; i++) begin
            pix_model[i] = 8'h00;
        end

        // Refresh right after reset reads an all-zero buffer.
        add_row(lmcr_pkg::OP_REFRESH,    2'd0, 3'd0, 3'd0, 1'b0, 8'h00, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_BRIGHTNESS, 2'd0, 3'd0, 3'd0, 1'b0, 8'd0,  CHK_FRAME,
                64'h0A000A000A000A00);
        add_row(lmcr_pkg::OP_BRIGHTNESS, 2'd1, 3'd2, 3'd4, 1'b1, 8'd14, CHK_FRAME,
                64'h0A0E0A0E0A0E0A0E);
        add_row(lmcr_pkg::OP_BRIGHTNESS, 2'd2, 3'd5, 3'd1, 1'b0, 8'd15, CHK_FRAME,
                64'h0A0F0A0F0A0F0A0F);
        add_row(lmcr_pkg::OP_BRIGHTNESS, 2'd3, 3'd7, 3'd7, 1'b1, 8'd16, CHK_FRAME,
                64'h0A0F0A0F0A0F0A0F);
        add_row(lmcr_pkg::OP_BRIGHTNESS, 2'd0, 3'd0, 3'd0, 1'b0, 8'd255, CHK_FRAME,
                64'h0A0F0A0F0A0F0A0F);
        add_row(lmcr_pkg::OP_SET_ROW,    2'd0, 3'd0, 3'd0, 1'b0, 8'hFF, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_SET_ROW,    2'd3, 3'd7, 3'd0, 1'b0, 8'h80, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_SET_ROW,    2'd1, 3'd3, 3'd0, 1'b0, 8'h5A, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_SET_ROW,    2'd2, 3'd4, 3'd0, 1'b0, 8'hA5, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_SET_PIXEL,  2'd0, 3'd0, 3'd7, 1'b0, 8'h00, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_SET_PIXEL,  2'd3, 3'd7, 3'd0, 1'b1, 8'h00, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_SET_PIXEL,  2'd2, 3'd5, 3'd3, 1'b1, 8'hFF, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_SET_PIXEL,  2'd1, 3'd3, 3'd1, 1'b0, 8'h00, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_REFRESH,    2'd3, 3'd7, 3'd7, 1'b1, 8'hFF, CHK_MODEL, '0);
        add_row(OP_SPARE_6,              2'd1, 3'd1, 3'd1, 1'b1, 8'h33, CHK_NONE,  '0);
        add_row(OP_SPARE_7,              2'd3, 3'd7, 3'd7, 1'b1, 8'hFF, CHK_NONE,  '0);
        add_row(lmcr_pkg::OP_SET_ROW,    2'd1, 3'd7, 3'd0, 1'b0, 8'h00, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_CLEAR,      2'd0, 3'd0, 3'd0, 1'b0, 8'h00, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_SET_ROW,    2'd2, 3'd2, 3'd0, 1'b0, 8'h3C, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_INIT,       2'd0, 3'd0, 3'd0, 1'b0, 8'h00, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_SET_PIXEL,  2'd0, 3'd6, 3'd4, 1'b1, 8'h00, CHK_MODEL, '0);
        add_row(lmcr_pkg::OP_REFRESH,    2'd0, 3'd0, 3'd0, 1'b0, 8'h00, CHK_MODEL, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_cmd(directed_rows[i]);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            // Every 25 commands, randomly pick a stretch with or without idling on both sides.
            if (i % 25 == 0) begin
                calm = ($urandom_range(0, 2) == 0);
            end
            send_cmd(random_cmd());
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        @(posedge i_clk);
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (err_count == 0) begin
            $display("PASS led_matrix_chain_refresh");
        end else begin
            $display("FAIL led_matrix_chain_refresh");
        end
        $finish;
    end

endmodule
